### hdl/rvm_pkg.sv
// Shared types, codes and constants for the resampling voice mixer.
// Used by rvm_div and resampling_voice_mixer; depends on nothing.
package rvm_pkg;

  // Request kinds carried in the input tuser field
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_MIX   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_BUFFER_RATE     = 3'd0;
  localparam logic [2:0] REG_RATE_MULTIPLIER = 3'd1;
  localparam logic [2:0] REG_OUTPUT_RATE     = 3'd2;
  localparam logic [2:0] REG_LEFT_VOLUME     = 3'd3;
  localparam logic [2:0] REG_RIGHT_VOLUME    = 3'd4;
  localparam logic [2:0] REG_AMPLITUDE       = 3'd5;
  localparam logic [2:0] REG_SAMPLE_MODE     = 3'd6;
  localparam logic [2:0] REG_FRAME_COUNT     = 3'd7;

  // Register reset values
  localparam logic [31:0] RST_BUFFER_RATE     = 32'd65536;
  localparam logic [31:0] RST_RATE_MULTIPLIER = 32'd65536;
  localparam logic [23:0] RST_OUTPUT_RATE     = 24'd44100;
  localparam logic [15:0] RST_LEFT_VOLUME     = 16'd256;
  localparam logic [15:0] RST_RIGHT_VOLUME    = 16'd256;
  localparam logic [7:0]  RST_AMPLITUDE       = 8'd255;
  localparam logic [3:0]  RST_SAMPLE_MODE     = 4'd0;
  localparam logic [16:0] RST_FRAME_COUNT     = 17'd0;

  // Sample formats, sample_mode bits 1:0
  localparam logic [1:0] FMT_U8    = 2'd0;
  localparam logic [1:0] FMT_S8    = 2'd1;
  localparam logic [1:0] FMT_S16LE = 2'd2;
  localparam logic [1:0] FMT_S16BE = 2'd3;

  localparam logic [7:0] U8_BIAS   = 8'h80;
  localparam logic [8:0] GAIN_DIV  = 9'd255;

  localparam int DIVD_W = 64;
  localparam int DIVS_W = 24;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  // floor(x / 255) for a 24-bit x: series estimate, then one correction step
  function automatic logic [15:0] gain_div255(input logic [23:0] x);
    logic [24:0] s;
    logic [16:0] q;
    logic [24:0] back;
    logic [24:0] rem;
    s    = {1'b0, x} + {9'b0, x[23:8]} + {17'b0, x[23:16]};
    q    = s[24:8];
    back = {q, 8'h00} - {8'b0, q};
    rem  = {1'b0, x} - back;
    if (rem >= {16'b0, GAIN_DIV}) begin
      q = q + 17'd1;
    end
    return q[15:0];
  endfunction

endpackage

### hdl/resampling_voice_mixer.sv
// One voice of a stereo resampling mixer; depends on rvm_pkg and rvm_div.
// Mix request: the serial divider for the position step sets the time from
// accept to result; the byte reads come first, and the later shared multiplier
// passes run alongside it. Load, start, silent mix and unknown requests skip it.
// One request at a time; the next is taken once the result is taken.
// Synchronous active-low reset: registers to defaults, voice stopped, position 0.
module resampling_voice_mixer #(
  parameter int SAMPLE_BYTES = 262144
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [17:0] byte_address, [25:18] byte_value, [57:26] mix_left_in,
  // [89:58] mix_right_in, [95:90] zero
  input  logic [95:0] in_tdata,
  // [1:0] op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [31:0] mix_left_out, [63:32] mix_right_out
  output logic [63:0] out_tdata,
  // [0] produced, [1] still_playing
  output logic [1:0]  out_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int          MEM_AW = $clog2(SAMPLE_BYTES);
  localparam logic [31:0] SB32   = 32'(SAMPLE_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_START, S_MIX, S_READ, S_MUL, S_WB, S_WAIT, S_RESP
  } state_t;

  typedef enum logic [2:0] {
    MS_STEP, MS_LGAIN, MS_RGAIN, MS_LINT, MS_RINT, MS_LSCALE, MS_RSCALE
  } mstep_t;

  state_t state_r;
  mstep_t mstep_r;

  // configuration
  logic [31:0] br_r, rm_r;
  logic [23:0] or_r;
  logic [15:0] lvol_r, rvol_r;
  logic [7:0]  amp_r;
  logic [3:0]  mode_r;
  logic [16:0] fc_r;

  // voice state and request payload
  logic        playing_r;
  logic [63:0] pos_r;
  logic        produced_r;
  logic        out_tvalid_r;
  logic [3:0]  rc_r;
  logic        interp_r;
  logic [1:0]  op_r;
  logic [17:0] addr_r;
  logic [7:0]  bval_r;
  logic [31:0] lacc_r, racc_r;
  logic [7:0]  byte_r [8];
  logic [7:0]  rd_r;
  logic [63:0] mul_r;
  logic [15:0] lgain_r, rgain_r;
  logic [16:0] l2_r, r2_r;

  logic [7:0] sample_mem [SAMPLE_BYTES];

  rvm_pkg::div_req_t div_req;
  rvm_pkg::div_rsp_t div_rsp;

  logic [31:0] frame;
  logic        silent, at_end, next_ok, stereo, wide;
  logic [2:0]  idx;
  logic [16:0] fsel;
  logic [17:0] tsel, raw_addr;
  logic [MEM_AW-1:0] mem_addr;
  logic [2:0]  rc_m1;
  logic signed [15:0] cur_l, cur_r, nxt_l, nxt_r;
  logic [16:0] diff_l, diff_r;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  logic [63:0] pos_nxt;

  // reduce an address into the memory, one compare and subtract per power of two
  function automatic logic [MEM_AW-1:0] mod_sb(input logic [17:0] a);
    logic [31:0] v;
    v = {14'b0, a};
    for (int k = 7; k >= 0; k--) begin
      if (v >= (SB32 << k)) begin
        v = v - (SB32 << k);
      end
    end
    return v[MEM_AW-1:0];
  endfunction

  function automatic logic signed [15:0] decode(input logic [1:0] fmt,
                                                input logic [7:0] b0,
                                                input logic [7:0] b1);
    logic [15:0] w;
    case (fmt)
      rvm_pkg::FMT_U8:    w = {b0 ^ rvm_pkg::U8_BIAS, 8'h00};
      rvm_pkg::FMT_S8:    w = {b0, 8'h00};
      rvm_pkg::FMT_S16LE: w = {b1, b0};
      rvm_pkg::FMT_S16BE: w = {b0, b1};
      default:            w = '0;
    endcase
    return signed'(w);
  endfunction

  always_comb begin
    frame   = pos_r[63:32];
    silent  = !playing_r || (rm_r == '0) || (or_r == '0);
    at_end  = frame >= {15'b0, fc_r};
    next_ok = ({1'b0, frame} + 33'd1) < {16'b0, fc_r};
    stereo  = mode_r[2];
    wide    = mode_r[1];

    // read index: bit0 second byte of a sample, bit1 right side, bit2 next frame
    idx      = rc_r[2:0];
    fsel     = frame[16:0] + {16'b0, idx[2]};
    tsel     = stereo ? {fsel, idx[1]} : {1'b0, fsel};
    raw_addr = wide ? {tsel[16:0], idx[0]} : tsel;
    mem_addr = mod_sb((state_r == S_LOAD) ? addr_r : raw_addr);
    rc_m1    = 3'(rc_r - 4'd1);

    cur_l  = decode(mode_r[1:0], byte_r[0], byte_r[1]);
    cur_r  = stereo ? decode(mode_r[1:0], byte_r[2], byte_r[3]) : cur_l;
    nxt_l  = decode(mode_r[1:0], byte_r[4], byte_r[5]);
    nxt_r  = stereo ? decode(mode_r[1:0], byte_r[6], byte_r[7]) : nxt_l;
    diff_l = {nxt_l[15], nxt_l} - {cur_l[15], cur_l};
    diff_r = {nxt_r[15], nxt_r} - {cur_r[15], cur_r};

    pos_nxt = pos_r + div_rsp.quotient;
  end

  // shared multiplier operand select
  always_comb begin
    unique case (mstep_r)
      MS_STEP: begin
        ma = {1'b0, br_r};
        mb = {1'b0, rm_r};
      end
      MS_LGAIN: begin
        ma = {17'b0, lvol_r};
        mb = {25'b0, amp_r};
      end
      MS_RGAIN: begin
        ma = {17'b0, rvol_r};
        mb = {25'b0, amp_r};
      end
      MS_LINT: begin
        ma = {{16{diff_l[16]}}, diff_l};
        mb = {17'b0, pos_r[31:16]};
      end
      MS_RINT: begin
        ma = {{16{diff_r[16]}}, diff_r};
        mb = {17'b0, pos_r[31:16]};
      end
      MS_LSCALE: begin
        ma = {{16{l2_r[16]}}, l2_r};
        mb = {17'b0, lgain_r};
      end
      MS_RSCALE: begin
        ma = {{16{r2_r[16]}}, r2_r};
        mb = {17'b0, rgain_r};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mprod = ma * mb;
  end

  always_ff @(posedge clk) begin
    mul_r <= mprod[63:0];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      sample_mem[mem_addr] <= bval_r;
    end
    rd_r <= sample_mem[mem_addr];
  end

  assign div_req.start    = (state_r == S_WB) && (mstep_r == MS_STEP);
  assign div_req.dividend = mul_r;
  assign div_req.divisor  = or_r;

  rvm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer, voice state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mstep_r      <= MS_STEP;
      playing_r    <= 1'b0;
      pos_r        <= '0;
      produced_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
      rc_r         <= '0;
      interp_r     <= 1'b0;
      br_r         <= rvm_pkg::RST_BUFFER_RATE;
      rm_r         <= rvm_pkg::RST_RATE_MULTIPLIER;
      or_r         <= rvm_pkg::RST_OUTPUT_RATE;
      lvol_r       <= rvm_pkg::RST_LEFT_VOLUME;
      rvol_r       <= rvm_pkg::RST_RIGHT_VOLUME;
      amp_r        <= rvm_pkg::RST_AMPLITUDE;
      mode_r       <= rvm_pkg::RST_SAMPLE_MODE;
      fc_r         <= rvm_pkg::RST_FRAME_COUNT;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          rvm_pkg::REG_BUFFER_RATE:     br_r   <= cfg_data;
          rvm_pkg::REG_RATE_MULTIPLIER: rm_r   <= cfg_data;
          rvm_pkg::REG_OUTPUT_RATE:     or_r   <= cfg_data[23:0];
          rvm_pkg::REG_LEFT_VOLUME:     lvol_r <= cfg_data[15:0];
          rvm_pkg::REG_RIGHT_VOLUME:    rvol_r <= cfg_data[15:0];
          rvm_pkg::REG_AMPLITUDE:       amp_r  <= cfg_data[7:0];
          rvm_pkg::REG_SAMPLE_MODE:     mode_r <= cfg_data[3:0];
          rvm_pkg::REG_FRAME_COUNT:     fc_r   <= cfg_data[16:0];
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            produced_r <= 1'b0;
            unique case (in_tuser)
              rvm_pkg::OP_LOAD:  state_r <= S_LOAD;
              rvm_pkg::OP_START: state_r <= S_START;
              rvm_pkg::OP_MIX:   state_r <= S_MIX;
              default: begin
                state_r      <= S_RESP;
                out_tvalid_r <= 1'b1;
              end
            endcase
          end
        end
        S_LOAD: begin
          state_r      <= S_RESP;
          out_tvalid_r <= 1'b1;
        end
        S_START: begin
          pos_r        <= '0;
          playing_r    <= 1'b1;
          state_r      <= S_RESP;
          out_tvalid_r <= 1'b1;
        end
        S_MIX: begin
          if (silent) begin
            state_r      <= S_RESP;
            out_tvalid_r <= 1'b1;
          end else if (at_end) begin
            playing_r    <= 1'b0;
            state_r      <= S_RESP;
            out_tvalid_r <= 1'b1;
          end else begin
            interp_r <= mode_r[3] && next_ok;
            rc_r     <= '0;
            state_r  <= S_READ;
          end
        end
        S_READ: begin
          if (rc_r == 4'd8) begin
            mstep_r <= MS_STEP;
            state_r <= S_MUL;
          end else begin
            rc_r <= rc_r + 4'd1;
          end
        end
        S_MUL: begin
          state_r <= S_WB;
        end
        S_WB: begin
          if (mstep_r == MS_RSCALE) begin
            state_r <= S_WAIT;
          end else begin
            mstep_r <= mstep_t'(mstep_r + 3'd1);
            state_r <= S_MUL;
          end
        end
        S_WAIT: begin
          // advance once the step quotient is ready
          if (!div_rsp.busy) begin
            pos_r        <= pos_nxt;
            playing_r    <= pos_nxt[63:32] < {15'b0, fc_r};
            produced_r   <= 1'b1;
            state_r      <= S_RESP;
            out_tvalid_r <= 1'b1;
          end
        end
        S_RESP: begin
          if (out_tready) begin
            out_tvalid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // request payload and mix datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      op_r   <= in_tuser;
      addr_r <= in_tdata[17:0];
      bval_r <= in_tdata[25:18];
      lacc_r <= in_tdata[57:26];
      racc_r <= in_tdata[89:58];
    end
    if (state_r == S_READ && rc_r != 4'd0) begin
      byte_r[rc_m1] <= rd_r;
    end
    if (state_r == S_WB) begin
      case (mstep_r)
        MS_LGAIN:  lgain_r <= rvm_pkg::gain_div255(mul_r[23:0]);
        MS_RGAIN:  rgain_r <= rvm_pkg::gain_div255(mul_r[23:0]);
        MS_LINT:   l2_r    <= interp_r ? {cur_l[15], cur_l} + mul_r[32:16]
                                       : {cur_l[15], cur_l};
        MS_RINT:   r2_r    <= interp_r ? {cur_r[15], cur_r} + mul_r[32:16]
                                       : {cur_r[15], cur_r};
        MS_LSCALE: lacc_r  <= lacc_r + mul_r[39:8];
        MS_RSCALE: racc_r  <= racc_r + mul_r[39:8];
        default: ;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {racc_r, lacc_r};
  assign out_tuser  = {playing_r, produced_r};
  assign cfg_ready  = 1'b1;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_produce_on_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (op_r == rvm_pkg::OP_MIX))
    else $error("frame produced by a request that is not a mix");

  a_start_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START) |=> (playing_r && pos_r == '0))
    else $error("start did not rewind the voice");

  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_WAIT && state_r != S_START) |=> $stable(pos_r))
    else $error("position moved outside start or step update");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

endmodule

### hdl/rvm_div.sv
// Serial restoring divider, one quotient bit per cycle while busy.
// Depends on rvm_pkg for the request and response structs.
module rvm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rvm_pkg::div_req_t req,
  output rvm_pkg::div_rsp_t rsp
);

  logic                       busy_r;
  logic [5:0]                 cnt_r;
  logic [rvm_pkg::DIVD_W-1:0] quo_r;
  logic [rvm_pkg::DIVS_W-1:0] rem_r;
  logic [rvm_pkg::DIVS_W-1:0] dvs_r;

  logic [rvm_pkg::DIVS_W:0]   trial;
  logic                       ge;
  logic [rvm_pkg::DIVS_W-1:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[rvm_pkg::DIVD_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? rvm_pkg::DIVS_W'(trial - {1'b0, dvs_r})
                 : trial[rvm_pkg::DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[rvm_pkg::DIVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.quotient = quo_r;

endmodule
